// ===== rtl/core/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Running statistics accumulator package
// Shared constants and types for the accumulator core.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // Width of the sum-of-squares accumulator.
    localparam int unsigned SQUARE_BITS = 48;

    // Sticky flags, one each for the sum, sum-of-squares and product accumulators.
    typedef struct packed {
        logic sum_ok;
        logic square_ok;
        logic product_ok;
    } ok_flags_t;

endpackage

// ===== rtl/core/rsa_input_stage.sv =====
// ----------------------------------------------------------------------------
// Running statistics input stage
// Registers the incoming sample together with its square.
// ----------------------------------------------------------------------------
module rsa_input_stage #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            advance,
    output logic                            hold_valid,
    output logic signed [SAMPLE_BITS-1:0]   hold_sample,
    output logic [2*SAMPLE_BITS-1:0]        hold_square
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    logic [2*SAMPLE_BITS-1:0]       square_reg;
    logic [SAMPLE_BITS-1:0]         magnitude;
    logic                           accept;

    // The stage may refill in the same cycle that the accumulator takes it.
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // For the most negative sample the magnitude is exactly 2^(SAMPLE_BITS-1).
    assign magnitude = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            square_reg <= {{SAMPLE_BITS{1'b0}}, magnitude} * {{SAMPLE_BITS{1'b0}}, magnitude};
        end
    end

    assign hold_valid  = valid_reg;
    assign hold_sample = sample_reg;
    assign hold_square = square_reg;

endmodule

// ===== rtl/core/rsa_accum.sv =====
// ----------------------------------------------------------------------------
// Running statistics accumulators
// Updates count, extremes, sum, sum of squares and product once per sample;
// the accumulator registers double as the result register.
// ----------------------------------------------------------------------------
module rsa_accum #(
    parameter int unsigned SAMPLE_BITS  = 16,
    parameter int unsigned COUNT_BITS   = 24,
    parameter int unsigned SUM_BITS     = 32,
    parameter int unsigned PRODUCT_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic signed [SAMPLE_BITS-1:0]       item_sample,
    input  logic [2*SAMPLE_BITS-1:0]            item_square,
    output logic                                take,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COUNT_BITS-1:0]               count,
    output logic signed [SAMPLE_BITS-1:0]       minimum,
    output logic signed [SAMPLE_BITS-1:0]       maximum,
    output logic signed [SUM_BITS-1:0]          total,
    output logic [rsa_pkg::SQUARE_BITS-1:0]     square_total,
    output logic signed [PRODUCT_BITS-1:0]      running_product,
    output rsa_pkg::ok_flags_t                  flags
);

    localparam int unsigned SQ_BITS   = rsa_pkg::SQUARE_BITS;
    localparam int unsigned SUM_WIDE  = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;
    localparam int unsigned SQ_WIDE   = ((SQ_BITS > 2 * SAMPLE_BITS) ? SQ_BITS
                                         : 2 * SAMPLE_BITS) + 1;
    localparam int unsigned PROD_WIDE = PRODUCT_BITS + SAMPLE_BITS;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [COUNT_BITS-1:0]              count_reg;
    logic [COUNT_BITS-1:0]              count_next;
    logic signed [SAMPLE_BITS-1:0]      min_reg;
    logic signed [SAMPLE_BITS-1:0]      min_next;
    logic signed [SAMPLE_BITS-1:0]      max_reg;
    logic signed [SAMPLE_BITS-1:0]      max_next;
    logic signed [SUM_BITS-1:0]         sum_reg;
    logic signed [SUM_BITS-1:0]         sum_next;
    logic [SQ_BITS-1:0]                 square_reg;
    logic [SQ_BITS-1:0]                 square_next;
    logic signed [PRODUCT_BITS-1:0]     product_reg;
    logic signed [PRODUCT_BITS-1:0]     product_next;
    rsa_pkg::ok_flags_t                 flags_reg;
    rsa_pkg::ok_flags_t                 flags_next;

    logic signed [SUM_WIDE-1:0]         sum_full;
    logic [SQ_WIDE-1:0]                 square_full;
    logic signed [PROD_WIDE-1:0]        product_full;
    logic                               sum_over;
    logic                               square_over;
    logic                               product_over;

    assign take = item_valid && (!out_valid_reg || !out_stall);

    // Exact results at full width; an overflow shows as high bits that are not a
    // plain extension of the result's sign bit (for the unsigned square: any high bit set).
    assign sum_full = {{(SUM_WIDE - SUM_BITS){sum_reg[SUM_BITS-1]}}, sum_reg}
                    + {{(SUM_WIDE - SAMPLE_BITS){item_sample[SAMPLE_BITS-1]}}, item_sample};
    assign sum_over = !((&sum_full[SUM_WIDE-1:SUM_BITS-1])
                        || !(|sum_full[SUM_WIDE-1:SUM_BITS-1]));

    assign square_full = {{(SQ_WIDE - SQ_BITS){1'b0}}, square_reg}
                       + {{(SQ_WIDE - 2 * SAMPLE_BITS){1'b0}}, item_square};
    assign square_over = |square_full[SQ_WIDE-1:SQ_BITS];

    assign product_full = PROD_WIDE'(product_reg) * PROD_WIDE'(item_sample);
    assign product_over = !((&product_full[PROD_WIDE-1:PRODUCT_BITS-1])
                            || !(|product_full[PROD_WIDE-1:PRODUCT_BITS-1]));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        square_next    = square_reg;
        product_next   = product_reg;
        flags_next     = flags_reg;

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            if (!(&count_reg))
            begin
                count_next = count_reg + 1'b1;
            end
            if (item_sample < min_reg)
            begin
                min_next = item_sample;
            end
            if (item_sample > max_reg)
            begin
                max_next = item_sample;
            end

            // Once a flag has dropped, its accumulator stays frozen.
            if (flags_reg.sum_ok)
            begin
                if (sum_over)
                begin
                    flags_next.sum_ok = 1'b0;
                    sum_next = sum_full[SUM_WIDE-1]
                             ? {1'b1, {(SUM_BITS-1){1'b0}}}
                             : {1'b0, {(SUM_BITS-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_full[SUM_BITS-1:0];
                end
            end

            if (flags_reg.square_ok)
            begin
                if (square_over)
                begin
                    flags_next.square_ok = 1'b0;
                    square_next = {SQ_BITS{1'b1}};
                end
                else
                begin
                    square_next = square_full[SQ_BITS-1:0];
                end
            end

            if (flags_reg.product_ok)
            begin
                if (product_over)
                begin
                    flags_next.product_ok = 1'b0;
                    product_next = product_full[PROD_WIDE-1]
                                 ? {1'b1, {(PRODUCT_BITS-1){1'b0}}}
                                 : {1'b0, {(PRODUCT_BITS-1){1'b1}}};
                end
                else
                begin
                    product_next = product_full[PRODUCT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            min_reg       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            max_reg       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            sum_reg       <= '0;
            square_reg    <= '0;
            product_reg   <= {{(PRODUCT_BITS-1){1'b0}}, 1'b1};
            flags_reg     <= '{sum_ok: 1'b1, square_ok: 1'b1, product_ok: 1'b1};
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            square_reg    <= square_next;
            product_reg   <= product_next;
            flags_reg     <= flags_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign count           = count_reg;
    assign minimum         = min_reg;
    assign maximum         = max_reg;
    assign total           = sum_reg;
    assign square_total    = square_reg;
    assign running_product = product_reg;
    assign flags           = flags_reg;

`ifndef NO_ASSERTIONS
    // Every shown result follows at least one sample, so the extremes are ordered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (min_reg <= max_reg))
        else $error("minimum exceeds maximum in a shown result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !(&count_reg)) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("sample count did not advance on a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(count_reg) && $stable(sum_reg) && $stable(product_reg)))
        else $error("accumulators changed without a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        !flags_reg.sum_ok |=> (!flags_reg.sum_ok && $stable(sum_reg)))
        else $error("sum resumed after overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !flags_reg.product_ok |=> (!flags_reg.product_ok && $stable(product_reg)))
        else $error("product resumed after overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(square_reg)))
        else $error("stalled result was dropped or changed");
`endif

endmodule

// ===== rtl/core/running_statistics_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// Running statistics accumulator unit
// Count, minimum, maximum, sum, sum of squares and product over a stream.
// ----------------------------------------------------------------------------
// The unit takes one signed sample per clock when not stalled and returns
// one result per sample holding all statistics after that sample. A sample
// passes through an input register (where its square is formed) and the
// accumulator registers, which also serve as the result register, so its
// result is presented straight from the accumulator registers once they
// have taken it. Throughput is one sample per cycle while out_stall stays
// low; it is set by the product loop, where the running product is multiplied
// by the sample, checked and saturated combinationally before it is registered.
// Sum, sum of squares and product each saturate on overflow, clear their *_ok
// flag and then hold until reset. Minimum and maximum are only meaningful once
// count is nonzero, which is true of every result.
module running_statistics_accumulator_unit #(
    parameter int unsigned SAMPLE_BITS  = 16,
    parameter int unsigned COUNT_BITS   = 24,
    parameter int unsigned SUM_BITS     = 32,
    parameter int unsigned PRODUCT_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COUNT_BITS-1:0]               count,
    output logic signed [SAMPLE_BITS-1:0]       minimum,
    output logic signed [SAMPLE_BITS-1:0]       maximum,
    output logic signed [SUM_BITS-1:0]          total,
    output logic                                total_ok,
    output logic [rsa_pkg::SQUARE_BITS-1:0]     square_total,
    output logic                                square_total_ok,
    output logic signed [PRODUCT_BITS-1:0]      running_product,
    output logic                                running_product_ok
);

    logic                           hold_valid;
    logic signed [SAMPLE_BITS-1:0]  hold_sample;
    logic [2*SAMPLE_BITS-1:0]       hold_square;
    logic                           advance;
    rsa_pkg::ok_flags_t             flags;

    rsa_input_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .advance     (advance),
        .hold_valid  (hold_valid),
        .hold_sample (hold_sample),
        .hold_square (hold_square)
    );

    rsa_accum #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .SUM_BITS     (SUM_BITS),
        .PRODUCT_BITS (PRODUCT_BITS)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (hold_valid),
        .item_sample     (hold_sample),
        .item_square     (hold_square),
        .take            (advance),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .count           (count),
        .minimum         (minimum),
        .maximum         (maximum),
        .total           (total),
        .square_total    (square_total),
        .running_product (running_product),
        .flags           (flags)
    );

    assign total_ok           = flags.sum_ok;
    assign square_total_ok    = flags.square_ok;
    assign running_product_ok = flags.product_ok;

endmodule
